>>> design/ldc_pkg.sv
package ldc_pkg;

    // Defaults for the top-level parameters
    localparam int COUNT_WIDTH_DEF   = 24;
    localparam int HEADING_WIDTH_DEF = 48;

    // Field widths
    localparam int GYRO_W     = 16;
    localparam int DIFF_W     = GYRO_W + 1;
    localparam int MS_W       = 10;
    localparam int ENC_W      = 8;
    localparam int DRIVE_W    = 9;
    localparam int PHASE_W    = 3;
    localparam int SPEED_W    = 8;
    localparam int TICKS_W    = 16;
    localparam int ANGLE_W    = 9;

    // Heading increment: (gyro - bias) * ms
    localparam int INC_W      = DIFF_W + MS_W;

    // Raw units times milliseconds that make one degree
    localparam int UNITS_PER_DEG = 131000;

    // Heading term: clamp at 256 degrees, times 3, divide by one degree
    localparam int HLIM_W     = 26;
    localparam logic [HLIM_W-1:0] HEAD_LIMIT = HLIM_W'(256 * UNITS_PER_DEG);
    localparam int DIVD_W     = HLIM_W + 1;
    localparam int QUO_W      = 10;
    localparam logic [DIVD_W-1:0] DIV_BASE = DIVD_W'(UNITS_PER_DEG) << (QUO_W - 1);

    // Turn target in raw units times milliseconds
    localparam int TARGET_W   = 26;

    // Iteration counters of the serial units
    localparam int STEP_W     = $clog2(MS_W > QUO_W ? MS_W : QUO_W);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CORRECTION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_TICKS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_BIAS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_ANGLE_DEG = 3'd5;

    localparam logic [SPEED_W-1:0]  DRIVE_SPEED_RST    = 8'd130;
    localparam logic [SPEED_W-1:0]  TURN_SPEED_RST     = 8'd100;
    localparam logic [SPEED_W-1:0]  MAX_CORRECTION_RST = 8'd40;
    localparam logic [TICKS_W-1:0]  CELL_TICKS_RST     = 16'd2071;
    localparam logic [GYRO_W-1:0]   GYRO_BIAS_RST      = 16'd0;
    localparam logic [ANGLE_W-1:0]  TURN_ANGLE_RST     = 9'd90;

    // Drive phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEG1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_TURN = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEG2 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE = 3'd4;

endpackage

>>> design/ldc_smul.sv
module ldc_smul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ldc_pkg::DIFF_W-1:0]   multiplicand,
    input  logic        [ldc_pkg::MS_W-1:0]     multiplier,
    output logic signed [ldc_pkg::INC_W-1:0]    product,
    output logic                                done
);

    logic                               busy_reg;
    logic                               done_reg;
    logic        [ldc_pkg::STEP_W-1:0]  step_reg;
    logic signed [ldc_pkg::INC_W-1:0]   mcand_reg;
    logic        [ldc_pkg::MS_W-1:0]    mplier_reg;
    logic signed [ldc_pkg::INC_W-1:0]   acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + ldc_pkg::STEP_W'(1);
                if (step_reg == ldc_pkg::STEP_W'(ldc_pkg::MS_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One multiplier bit per cycle, LSB first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= ldc_pkg::INC_W'(multiplicand);
            mplier_reg <= multiplier;
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

>>> design/ldc_sdiv.sv
module ldc_sdiv (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ldc_pkg::DIVD_W-1:0]      dividend,
    output logic [ldc_pkg::QUO_W-1:0]       quotient,
    output logic                            done
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [ldc_pkg::STEP_W-1:0]     step_reg;
    logic [ldc_pkg::DIVD_W-1:0]     rem_reg;
    logic [ldc_pkg::DIVD_W-1:0]     dvsr_reg;
    logic [ldc_pkg::QUO_W-1:0]      quo_reg;
    logic                           fits;

    assign fits = (rem_reg >= dvsr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + ldc_pkg::STEP_W'(1);
                if (step_reg == ldc_pkg::STEP_W'(ldc_pkg::QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Restoring division by one degree, one quotient bit per cycle, MSB first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dvsr_reg <= ldc_pkg::DIV_BASE;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dvsr_reg;
            end
            quo_reg  <= {quo_reg[ldc_pkg::QUO_W-2:0], fits};
            dvsr_reg <= dvsr_reg >> 1;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> design/l_path_drive_controller.sv
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_wr_en                 cfg_index, cfg_wr_data
// in        in         in_valid / in_stall       go_pressed, reset_pressed, gyro_z,
//                                                elapsed_ms, enc_delta_right, enc_delta_left
// out       out        out_valid / out_stall     motor_a_drive, motor_b_drive,
//                                                driver_enable, phase
//
// One transaction in gives one transaction out. Every tick runs the bit-serial heading
// multiply; while driving straight it also runs the bit-serial divide of the heading term.
// in_stall is high from acceptance until the result is moved into the output register;
// a result waiting there under out_stall does not block the next transaction.
// rst_n clears phase, heading, counts and the registers to their defaults.
module l_path_drive_controller #(
    parameter int COUNT_WIDTH   = ldc_pkg::COUNT_WIDTH_DEF,
    parameter int HEADING_WIDTH = ldc_pkg::HEADING_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic        [ldc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic        [ldc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    go_pressed,
    input  logic                                    reset_pressed,
    input  logic signed [ldc_pkg::GYRO_W-1:0]       gyro_z,
    input  logic        [ldc_pkg::MS_W-1:0]         elapsed_ms,
    input  logic signed [ldc_pkg::ENC_W-1:0]        enc_delta_right,
    input  logic signed [ldc_pkg::ENC_W-1:0]        enc_delta_left,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [ldc_pkg::DRIVE_W-1:0]      motor_a_drive,
    output logic signed [ldc_pkg::DRIVE_W-1:0]      motor_b_drive,
    output logic                                    driver_enable,
    output logic        [ldc_pkg::PHASE_W-1:0]      phase
);

    localparam int CW  = COUNT_WIDTH;
    localparam int HW  = HEADING_WIDTH;
    localparam int HW1 = HW + 1;
    localparam int AW  = CW + 1;
    localparam int EW  = CW + 2;
    localparam int DW  = ldc_pkg::DRIVE_W;
    localparam int SW  = DW + 1;
    localparam int MW  = DW + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_HEAD  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_PREP  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_FINAL = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    localparam logic signed [HW-1:0] HEAD_MAX = {1'b0, {(HW - 1){1'b1}}};
    localparam logic signed [HW-1:0] HEAD_MIN = {1'b1, {(HW - 1){1'b0}}};

    function automatic logic signed [DW-1:0] sat_drive(input logic signed [MW-1:0] v);
        logic signed [DW-1:0] r;
        begin
            if (v > MW'(255))
                r = DW'(255);
            else if (v < -MW'(255))
                r = -DW'(255);
            else
                r = DW'(v);
            return r;
        end
    endfunction

    // Configuration
    logic        [ldc_pkg::SPEED_W-1:0]  drive_speed_reg;
    logic        [ldc_pkg::SPEED_W-1:0]  turn_speed_reg;
    logic        [ldc_pkg::SPEED_W-1:0]  max_corr_reg;
    logic        [ldc_pkg::TICKS_W-1:0]  cell_ticks_reg;
    logic signed [ldc_pkg::GYRO_W-1:0]   gyro_bias_reg;
    logic        [ldc_pkg::ANGLE_W-1:0]  turn_angle_reg;

    // Control state
    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [ldc_pkg::PHASE_W-1:0]    phase_reg;
    logic signed [HW-1:0]           heading_reg;
    logic signed [CW-1:0]           count_r_reg;
    logic signed [CW-1:0]           count_l_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // Per-tick payload
    logic                               go_reg;
    logic                               rstb_reg;
    logic [ldc_pkg::TARGET_W-1:0]       target_reg;
    logic signed [DW-1:0]               ce_reg;
    logic                               leg_end_reg;
    logic                               head_sign_reg;
    logic signed [DW-1:0]               res_a_reg;
    logic signed [DW-1:0]               res_b_reg;
    logic                               res_en_reg;
    logic signed [DW-1:0]               out_a_reg;
    logic signed [DW-1:0]               out_b_reg;
    logic                               out_en_reg;
    logic [ldc_pkg::PHASE_W-1:0]        out_phase_reg;

    // Datapath
    logic                               in_take;
    logic                               out_load;
    logic signed [ldc_pkg::DIFF_W-1:0]  gyro_diff;
    logic signed [ldc_pkg::INC_W-1:0]   head_inc;
    logic                               mul_done;
    logic                               div_done;
    logic [ldc_pkg::QUO_W-1:0]          quo;
    logic [ldc_pkg::PHASE_W-1:0]        ph_eff;
    logic                               go_start;
    logic                               ph_drive;
    logic signed [HW1-1:0]              head_sum;
    logic signed [HW-1:0]               head_sat;
    logic        [HW-1:0]               head_mag;
    logic                               turn_hit;
    logic [ldc_pkg::HLIM_W-1:0]         hclamp_mag;
    logic [ldc_pkg::DIVD_W-1:0]         div_dividend;
    logic        [AW-1:0]               mag_r;
    logic        [AW-1:0]               mag_l;
    logic signed [EW-1:0]               enc_err;
    logic signed [EW-1:0]               enc_q;
    logic signed [EW-1:0]               lim_e;
    logic signed [DW-1:0]               ce_calc;
    logic        [EW-1:0]               sum_mag;
    logic                               leg_end_calc;
    logic signed [DW-1:0]               lim_d;
    logic [ldc_pkg::QUO_W-1:0]          cg_mag;
    logic signed [DW-1:0]               cg;
    logic signed [SW-1:0]               corr_sum;
    logic signed [DW-1:0]               corr;
    logic signed [MW-1:0]               speed_e;
    logic signed [DW-1:0]               turn_drive;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    assign gyro_diff = ldc_pkg::DIFF_W'(gyro_z) - ldc_pkg::DIFF_W'(gyro_bias_reg);

    ldc_smul u_smul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_take),
        .multiplicand (gyro_diff),
        .multiplier   (elapsed_ms),
        .product      (head_inc),
        .done         (mul_done)
    );

    ldc_sdiv u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_PREP),
        .dividend (div_dividend),
        .quotient (quo),
        .done     (div_done)
    );

    // Phase in force after the reset button
    assign ph_eff   = rstb_reg ? ldc_pkg::PH_IDLE : phase_reg;
    assign go_start = go_reg && (ph_eff == ldc_pkg::PH_IDLE);
    assign ph_drive = (ph_eff == ldc_pkg::PH_LEG1) || (ph_eff == ldc_pkg::PH_LEG2);

    // Saturating heading update
    assign head_sum = HW1'(heading_reg) + HW1'(head_inc);
    always_comb
    begin
        if (head_sum[HW] != head_sum[HW-1])
            head_sat = head_sum[HW] ? HEAD_MIN : HEAD_MAX;
        else
            head_sat = head_sum[HW-1:0];
    end

    assign head_mag = heading_reg[HW-1] ? HW'(-heading_reg) : HW'(heading_reg);
    assign turn_hit = (head_mag >= HW'(target_reg));

    // Heading term dividend: |clamped heading| * 3
    assign hclamp_mag   = (head_mag > HW'(ldc_pkg::HEAD_LIMIT)) ? ldc_pkg::HEAD_LIMIT
                                                                : head_mag[ldc_pkg::HLIM_W-1:0];
    assign div_dividend = {hclamp_mag, 1'b0} + ldc_pkg::DIVD_W'(hclamp_mag);

    // Encoder term, truncated toward zero
    assign mag_r   = count_r_reg[CW-1] ? AW'(-AW'(count_r_reg)) : AW'(count_r_reg);
    assign mag_l   = count_l_reg[CW-1] ? AW'(-AW'(count_l_reg)) : AW'(count_l_reg);
    assign enc_err = signed'(EW'(mag_l)) - signed'(EW'(mag_r));
    assign enc_q   = enc_err[EW-1] ? ((enc_err + EW'(3)) >>> 2) : (enc_err >>> 2);
    assign lim_e   = signed'(EW'(max_corr_reg));
    assign lim_d   = signed'(DW'(max_corr_reg));

    always_comb
    begin
        if (enc_q > lim_e)
            ce_calc = lim_d;
        else if (enc_q < -lim_e)
            ce_calc = -lim_d;
        else
            ce_calc = DW'(enc_q);
    end

    assign sum_mag      = EW'(mag_r) + EW'(mag_l);
    assign leg_end_calc = ((sum_mag >> 1) >= EW'(cell_ticks_reg));

    // Steering sum and motor drives
    assign cg_mag   = (quo > ldc_pkg::QUO_W'(max_corr_reg)) ? ldc_pkg::QUO_W'(max_corr_reg) : quo;
    assign cg       = head_sign_reg ? -signed'(DW'(cg_mag)) : signed'(DW'(cg_mag));
    assign corr_sum = SW'(ce_reg) + SW'(cg);

    always_comb
    begin
        if (corr_sum > SW'(lim_d))
            corr = lim_d;
        else if (corr_sum < -SW'(lim_d))
            corr = -lim_d;
        else
            corr = DW'(corr_sum);
    end

    assign speed_e    = signed'(MW'(drive_speed_reg));
    assign turn_drive = -signed'(DW'(turn_speed_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_done)
                    state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                if (go_start)
                    state_next = ST_EMIT;
                else if (ph_drive)
                    state_next = ST_PREP;
                else if (ph_eff == ldc_pkg::PH_TURN)
                    state_next = ST_CHECK;
                else
                    state_next = ST_EMIT;
            end
            ST_CHECK: state_next = ST_EMIT;
            ST_PREP:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_FINAL;
            end
            ST_FINAL: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= ldc_pkg::PH_IDLE;
            heading_reg     <= '0;
            count_r_reg     <= '0;
            count_l_reg     <= '0;
            out_valid_reg   <= 1'b0;
            drive_speed_reg <= ldc_pkg::DRIVE_SPEED_RST;
            turn_speed_reg  <= ldc_pkg::TURN_SPEED_RST;
            max_corr_reg    <= ldc_pkg::MAX_CORRECTION_RST;
            cell_ticks_reg  <= ldc_pkg::CELL_TICKS_RST;
            gyro_bias_reg   <= ldc_pkg::GYRO_BIAS_RST;
            turn_angle_reg  <= ldc_pkg::TURN_ANGLE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    ldc_pkg::REG_DRIVE_SPEED:    drive_speed_reg <= cfg_wr_data[7:0];
                    ldc_pkg::REG_TURN_SPEED:     turn_speed_reg  <= cfg_wr_data[7:0];
                    ldc_pkg::REG_MAX_CORRECTION: max_corr_reg    <= cfg_wr_data[7:0];
                    ldc_pkg::REG_CELL_TICKS:     cell_ticks_reg  <= cfg_wr_data;
                    ldc_pkg::REG_GYRO_BIAS:      gyro_bias_reg   <= cfg_wr_data;
                    ldc_pkg::REG_TURN_ANGLE_DEG: turn_angle_reg  <= cfg_wr_data[8:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    // counts wrap within their width
                    if (in_take)
                    begin
                        count_r_reg <= count_r_reg + CW'(enc_delta_right);
                        count_l_reg <= count_l_reg + CW'(enc_delta_left);
                    end
                end
                ST_HEAD:
                begin
                    if (go_start)
                    begin
                        phase_reg   <= ldc_pkg::PH_LEG1;
                        heading_reg <= '0;
                        count_r_reg <= '0;
                        count_l_reg <= '0;
                    end
                    else if (ph_drive || (ph_eff == ldc_pkg::PH_TURN))
                    begin
                        heading_reg <= head_sat;
                    end
                    else
                    begin
                        phase_reg <= ph_eff;
                        if (rstb_reg)
                            heading_reg <= '0;
                    end
                end
                ST_CHECK:
                begin
                    if (turn_hit)
                    begin
                        phase_reg   <= ldc_pkg::PH_LEG2;
                        heading_reg <= '0;
                        count_r_reg <= '0;
                        count_l_reg <= '0;
                    end
                end
                ST_FINAL:
                begin
                    if (leg_end_reg)
                    begin
                        if (phase_reg == ldc_pkg::PH_LEG1)
                        begin
                            heading_reg <= '0;
                            phase_reg   <= ldc_pkg::PH_TURN;
                        end
                        else
                        begin
                            phase_reg <= ldc_pkg::PH_DONE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            go_reg     <= go_pressed;
            rstb_reg   <= reset_pressed;
            target_reg <= ldc_pkg::TARGET_W'(turn_angle_reg)
                          * ldc_pkg::TARGET_W'(ldc_pkg::UNITS_PER_DEG);
        end

        case (state_reg)
            ST_HEAD:
            begin
                res_a_reg  <= '0;
                res_b_reg  <= '0;
                res_en_reg <= go_start;
            end
            ST_CHECK:
            begin
                res_a_reg  <= turn_hit ? DW'(0) : turn_drive;
                res_b_reg  <= turn_hit ? DW'(0) : turn_drive;
                res_en_reg <= 1'b1;
            end
            ST_PREP:
            begin
                ce_reg        <= ce_calc;
                leg_end_reg   <= leg_end_calc;
                head_sign_reg <= heading_reg[HW-1];
            end
            ST_FINAL:
            begin
                if (!leg_end_reg)
                begin
                    res_a_reg  <= sat_drive(-(speed_e + MW'(corr)));
                    res_b_reg  <= sat_drive(speed_e - MW'(corr));
                    res_en_reg <= 1'b1;
                end
                else if (phase_reg == ldc_pkg::PH_LEG1)
                begin
                    res_a_reg  <= turn_drive;
                    res_b_reg  <= turn_drive;
                    res_en_reg <= 1'b1;
                end
                else
                begin
                    res_a_reg  <= '0;
                    res_b_reg  <= '0;
                    res_en_reg <= 1'b0;
                end
            end
            default: ;
        endcase

        // hold the result until the output register frees up
        if (out_load)
        begin
            out_a_reg     <= res_a_reg;
            out_b_reg     <= res_b_reg;
            out_en_reg    <= res_en_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign motor_a_drive = out_a_reg;
    assign motor_b_drive = out_b_reg;
    assign driver_enable = out_en_reg;
    assign phase         = out_phase_reg;

endmodule

>>> design/ldc_checker.sv
module ldc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [ldc_pkg::DRIVE_W-1:0]   motor_a_drive,
    input logic signed [ldc_pkg::DRIVE_W-1:0]   motor_b_drive,
    input logic                                 driver_enable,
    input logic        [ldc_pkg::PHASE_W-1:0]   phase
);

    // Idle and done always stop the motors and drop the driver
    a_stopped_phases: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == ldc_pkg::PH_IDLE || phase == ldc_pkg::PH_DONE)
        |-> motor_a_drive == '0 && motor_b_drive == '0 && !driver_enable)
        else $error("motors not stopped in idle or done");

    // Every active phase keeps the driver enabled
    a_active_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (phase == ldc_pkg::PH_LEG1 || phase == ldc_pkg::PH_TURN
                      || phase == ldc_pkg::PH_LEG2)
        |-> driver_enable)
        else $error("driver disabled in an active phase");

    // Turning in place drives both motors alike
    a_turn_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase == ldc_pkg::PH_TURN |-> motor_a_drive == motor_b_drive)
        else $error("motor drives differ while turning");

    // Saturation never reaches -256
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> motor_a_drive != -256 && motor_b_drive != -256)
        else $error("motor drive outside +-255");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(motor_a_drive)
            && $stable(motor_b_drive) && $stable(driver_enable) && $stable(phase))
        else $error("stalled output transaction changed");

endmodule

bind l_path_drive_controller ldc_checker u_ldc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .motor_a_drive (motor_a_drive),
    .motor_b_drive (motor_b_drive),
    .driver_enable (driver_enable),
    .phase         (phase)
);

>>> tb/l_path_drive_controller_tb.sv
`timescale 1ns / 100ps

module l_path_drive_controller_tb;
    import ldc_pkg::*;

    localparam int CNT_W      = COUNT_WIDTH_DEF;
    localparam int HEAD_W     = HEADING_WIDTH_DEF;
    localparam int IDLE_LIMIT = 3000;
    localparam int RAND_SETS  = 10;
    localparam int RAND_TICKS = 113;
    localparam int HOLD_LEN   = 400;

    // Indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct {
        logic                      go;
        logic                      rst;
        logic signed [GYRO_W-1:0]  gyro;
        logic        [MS_W-1:0]    ms;
        logic signed [ENC_W-1:0]   d_right;
        logic signed [ENC_W-1:0]   d_left;
    } tick_t;

    typedef struct {
        logic signed [DRIVE_W-1:0] motor_a;
        logic signed [DRIVE_W-1:0] motor_b;
        logic                      enable;
        logic        [PHASE_W-1:0] phase;
    } drive_t;

    typedef struct {
        logic        [SPEED_W-1:0] drive_speed;
        logic        [SPEED_W-1:0] turn_speed;
        logic        [SPEED_W-1:0] max_corr;
        logic        [TICKS_W-1:0] cell_ticks;
        logic signed [GYRO_W-1:0]  bias;
        logic        [ANGLE_W-1:0] angle;
    } regs_t;

    class drive_scoreboard;
        regs_t                    regs;
        logic [PHASE_W-1:0]       drive_phase;
        longint                   heading;
        logic signed [CNT_W-1:0]  count_r;
        logic signed [CNT_W-1:0]  count_l;
        drive_t                   motor_q[$];
        int                       mismatches;
        int                       checked;
        int                       ticks;
        int                       leg_ticks;
        int                       turns;
        int                       paths;

        function new();
            regs = '{DRIVE_SPEED_RST, TURN_SPEED_RST, MAX_CORRECTION_RST, CELL_TICKS_RST,
                     GYRO_BIAS_RST, TURN_ANGLE_RST};
            drive_phase = PH_IDLE;
            heading = 0;
            count_r = '0;
            count_l = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DRIVE_SPEED:    regs.drive_speed = data[SPEED_W-1:0];
                REG_TURN_SPEED:     regs.turn_speed  = data[SPEED_W-1:0];
                REG_MAX_CORRECTION: regs.max_corr    = data[SPEED_W-1:0];
                REG_CELL_TICKS:     regs.cell_ticks  = data[TICKS_W-1:0];
                REG_GYRO_BIAS:      regs.bias        = data[GYRO_W-1:0];
                REG_TURN_ANGLE_DEG: regs.angle       = data[ANGLE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function longint abs_of(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // saturate at the signed heading range
        function void add_heading(longint inc);
            longint top;
            longint sum;
            top = (longint'(1) <<< (HEAD_W - 1)) - 1;
            sum = heading + inc;
            if (sum > top)
                heading = top;
            else if (sum < -top - 1)
                heading = -top - 1;
            else
                heading = sum;
        endfunction

        function void note_tick(tick_t t);
            drive_t want;
            longint inc;
            longint lim;
            longint err;
            longint ce;
            longint h;
            longint cg;
            longint corr;
            inc = (longint'(t.gyro) - longint'(regs.bias)) * longint'(t.ms);
            lim = longint'(regs.max_corr);
            want.motor_a = '0;
            want.motor_b = '0;
            want.enable = 1'b0;
            ticks++;
            count_r = count_r + t.d_right;
            count_l = count_l + t.d_left;
            if (t.rst)
            begin
                drive_phase = PH_IDLE;
                heading = 0;
            end
            if (t.go && drive_phase == PH_IDLE)
            begin
                drive_phase = PH_LEG1;
                heading = 0;
                count_r = '0;
                count_l = '0;
                want.enable = 1'b1;
            end
            else if (drive_phase == PH_LEG1 || drive_phase == PH_LEG2)
            begin
                leg_ticks++;
                add_heading(inc);
                err = abs_of(count_l) - abs_of(count_r);
                ce = clamp(err / 4, lim);
                h = clamp(heading, longint'(256) * UNITS_PER_DEG);
                cg = clamp(h * 3 / UNITS_PER_DEG, lim);
                corr = clamp(ce + cg, lim);
                want.motor_a = DRIVE_W'(clamp(-(longint'(regs.drive_speed) + corr), 255));
                want.motor_b = DRIVE_W'(clamp(longint'(regs.drive_speed) - corr, 255));
                want.enable = 1'b1;
                if ((abs_of(count_r) + abs_of(count_l)) / 2 >= longint'(regs.cell_ticks))
                begin
                    if (drive_phase == PH_LEG1)
                    begin
                        heading = 0;
                        drive_phase = PH_TURN;
                        want.motor_a = DRIVE_W'(-longint'(regs.turn_speed));
                        want.motor_b = DRIVE_W'(-longint'(regs.turn_speed));
                    end
                    else
                    begin
                        paths++;
                        drive_phase = PH_DONE;
                        want.motor_a = '0;
                        want.motor_b = '0;
                        want.enable = 1'b0;
                    end
                end
            end
            else if (drive_phase == PH_TURN)
            begin
                add_heading(inc);
                want.enable = 1'b1;
                want.motor_a = DRIVE_W'(-longint'(regs.turn_speed));
                want.motor_b = DRIVE_W'(-longint'(regs.turn_speed));
                if (abs_of(heading) >= longint'(regs.angle) * UNITS_PER_DEG)
                begin
                    turns++;
                    drive_phase = PH_LEG2;
                    heading = 0;
                    count_r = '0;
                    count_l = '0;
                    want.motor_a = '0;
                    want.motor_b = '0;
                end
            end
            want.phase = drive_phase;
            motor_q.push_back(want);
        endfunction

        function void flag(string what, string want, string got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at result %0d: %s expected %s got %s",
                         checked, what, want, got);
        endfunction

        function void check_result(drive_t got);
            drive_t want;
            if (motor_q.size() == 0)
            begin
                flag("result with nothing outstanding", "none",
                     $sformatf("phase %0d", got.phase));
                return;
            end
            want = motor_q.pop_front();
            checked++;
            if (got.motor_a !== want.motor_a)
                flag("motor_a_drive", $sformatf("%0d", want.motor_a),
                     $sformatf("%0d", got.motor_a));
            if (got.motor_b !== want.motor_b)
                flag("motor_b_drive", $sformatf("%0d", want.motor_b),
                     $sformatf("%0d", got.motor_b));
            if (got.enable !== want.enable)
                flag("driver_enable", $sformatf("%0b", want.enable),
                     $sformatf("%0b", got.enable));
            if (got.phase !== want.phase)
                flag("phase", $sformatf("%0d", want.phase), $sformatf("%0d", got.phase));
        endfunction

        function int pending();
            return motor_q.size();
        endfunction

        function void summary(int settings);
            $display("Drove %0d ticks under %0d register settings: %0d straight-leg ticks,",
                     ticks, settings, leg_ticks);
            $display("%0d turns, %0d complete paths; %0d results checked, %0d mismatches.",
                     turns, paths, checked, mismatches);
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_wr_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       go_pressed;
    logic                       reset_pressed;
    logic signed [GYRO_W-1:0]   gyro_z;
    logic [MS_W-1:0]            elapsed_ms;
    logic signed [ENC_W-1:0]    enc_delta_right;
    logic signed [ENC_W-1:0]    enc_delta_left;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [DRIVE_W-1:0]  motor_a_drive;
    logic signed [DRIVE_W-1:0]  motor_b_drive;
    logic                       driver_enable;
    logic [PHASE_W-1:0]         phase;

    drive_scoreboard board;
    drive_t          seen;
    int              burst_left = 0;
    int              quiet_cycles = 0;

    l_path_drive_controller u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .go_pressed      (go_pressed),
        .reset_pressed   (reset_pressed),
        .gyro_z          (gyro_z),
        .elapsed_ms      (elapsed_ms),
        .enc_delta_right (enc_delta_right),
        .enc_delta_left  (enc_delta_left),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .motor_a_drive   (motor_a_drive),
        .motor_b_drive   (motor_b_drive),
        .driver_enable   (driver_enable),
        .phase           (phase)
    );

    always #2 clk = ~clk;

    function automatic tick_t tick_of(bit go, bit rst, int gz, int ms, int dr, int dl);
        tick_t t;
        t.go = go;
        t.rst = rst;
        t.gyro = GYRO_W'(gz);
        t.ms = MS_W'(ms);
        t.d_right = ENC_W'(dr);
        t.d_left = ENC_W'(dl);
        return t;
    endfunction

    function automatic logic signed [ENC_W-1:0] sat_enc(int v);
        if (v > 127)
            return 8'sd127;
        if (v < -128)
            return -8'sd128;
        return ENC_W'(v);
    endfunction

    // Mostly well-formed ticks for the phase in force, with some noise mixed in
    function automatic tick_t random_tick(logic [PHASE_W-1:0] ph);
        tick_t t;
        int base;
        int pace;
        int rate;
        base = int'(board.regs.bias);
        t = tick_of($urandom_range(0, 1), $urandom_range(0, 7) == 0,
                    $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 99) < 12)
            return t;
        t.go = 1'b0;
        t.rst = 1'b0;
        case (ph)
            PH_IDLE:
                t.go = $urandom_range(0, 9) < 7;
            PH_LEG1, PH_LEG2:
            begin
                pace = $urandom_range(0, 127);
                if ($urandom_range(0, 4) == 0)
                    pace = -pace;
                rate = $urandom_range(0, 40);
                t.d_right = sat_enc(pace);
                t.d_left = sat_enc(pace + rate - 20);
                rate = $urandom_range(0, 4000);
                t.gyro = GYRO_W'(base + rate - 2000);
                t.ms = MS_W'($urandom_range(1, 60));
                t.rst = $urandom_range(0, 49) == 0;
                t.go = $urandom_range(0, 19) == 0;
            end
            PH_TURN:
            begin
                rate = $urandom_range(2000, 30000);
                if ($urandom_range(0, 1))
                    rate = -rate;
                t.gyro = GYRO_W'(base + rate);
                t.ms = MS_W'($urandom_range(1, 300));
                t.rst = $urandom_range(0, 49) == 0;
            end
            PH_DONE:
            begin
                t.rst = $urandom_range(0, 2) == 0;
                t.go = $urandom_range(0, 1);
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic regs_t pick_regs(int p);
        regs_t c;
        c.drive_speed = SPEED_W'($urandom);
        c.turn_speed = SPEED_W'($urandom);
        c.max_corr = SPEED_W'($urandom);
        c.cell_ticks = ($urandom_range(0, 3) == 0) ? TICKS_W'($urandom_range(0, 3000))
                                                   : TICKS_W'($urandom_range(0, 400));
        c.bias = ($urandom_range(0, 3) == 0) ? GYRO_W'($urandom)
                                             : GYRO_W'($urandom_range(0, 1000) - 500);
        c.angle = ($urandom_range(0, 4) == 0) ? ANGLE_W'($urandom)
                                              : ANGLE_W'($urandom_range(1, 360));
        case (p)
            0: c = '{DRIVE_SPEED_RST, TURN_SPEED_RST, MAX_CORRECTION_RST, CELL_TICKS_RST,
                     GYRO_BIAS_RST, TURN_ANGLE_RST};
            1: c = '{8'd255, 8'd255, 8'd255, 16'hFFFF, 16'sh7FFF, 9'd511};
            2: c = '{8'd0, 8'd0, 8'd0, 16'd0, 16'sh8000, 9'd0};
            3: c = '{8'd255, 8'd0, 8'd255, 16'd1, 16'sh8000, 9'd360};
            default: ;
        endcase
        return c;
    endfunction

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // Unused upper data bits carry junk; the block must drop them
    task automatic program_regs(regs_t c);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        put_reg(REG_DRIVE_SPEED, {junk[15:8], c.drive_speed});
        put_reg(REG_TURN_SPEED, {junk[7:0], c.turn_speed});
        put_reg(REG_MAX_CORRECTION, {junk[15:8], c.max_corr});
        put_reg(REG_CELL_TICKS, c.cell_ticks);
        put_reg(REG_GYRO_BIAS, c.bias);
        put_reg(REG_TURN_ANGLE_DEG, {junk[6:0], c.angle});
        put_reg(REG_SPARE_A, junk);
        put_reg(REG_SPARE_B, ~junk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one tick, in bursts with random gaps between them
    task automatic push_tick(tick_t t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        go_pressed <= t.go;
        reset_pressed <= t.rst;
        gyro_z <= t.gyro;
        elapsed_ms <= t.ms;
        enc_delta_right <= t.d_right;
        enc_delta_left <= t.d_left;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        board.note_tick(t);
    endtask

    // Drain: wait until every outstanding tick has produced its result
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.motor_a = motor_a_drive;
            seen.motor_b = motor_b_drive;
            seen.enable = driver_enable;
            seen.phase = phase;
            board.check_result(seen);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("no transaction for %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Receiver: random stall patterns, with a long hold now and then so the block backs up
    initial
    begin
        int segment;
        int len;
        int mode;
        out_stall = 1'b0;
        segment = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            segment++;
            if (segment % 150 == 40)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            len = $urandom_range(10, 80);
            for (int i = 0; i < len; i++)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= $urandom_range(0, 99) < 35;
                    2: out_stall <= $urandom_range(0, 99) < 80;
                    default: out_stall <= (i % 7) < 4;
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        tick_t opening_q[$];
        tick_t zero_q[$];
        int    settings;
        board = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        go_pressed = 1'b0;
        reset_pressed = 1'b0;
        gyro_z = '0;
        elapsed_ms = '0;
        enc_delta_right = '0;
        enc_delta_left = '0;
        settings = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: idle extremes, reset in idle, go, corrections at full scale,
        // go ignored while driving, reset while driving, reset and go together
        opening_q.push_back(tick_of(0, 0, 32767, 1023, 127, -128));
        opening_q.push_back(tick_of(0, 1, -32768, 0, -128, 127));
        opening_q.push_back(tick_of(1, 0, 100, 20, 5, 5));
        opening_q.push_back(tick_of(0, 0, 32767, 1023, 127, 127));
        opening_q.push_back(tick_of(0, 0, -32768, 1023, -128, 100));
        opening_q.push_back(tick_of(0, 0, 0, 0, 0, 0));
        opening_q.push_back(tick_of(1, 0, 50, 10, 30, 40));
        opening_q.push_back(tick_of(0, 1, 50, 10, 30, 40));
        opening_q.push_back(tick_of(1, 1, -7, 3, 1, -1));
        foreach (opening_q[i])
            push_tick(opening_q[i]);
        settle();

        // Zero distance and zero angle: each leg and the turn end on their first tick;
        // then go ignored when done, reset with go from done, reset while turning
        program_regs('{8'd255, 8'd255, 8'd255, 16'd0, 16'sh8000, 9'd0});
        settings++;
        zero_q.push_back(tick_of(0, 0, 32767, 1023, 127, 127));
        zero_q.push_back(tick_of(0, 0, -32768, 0, 0, 0));
        zero_q.push_back(tick_of(0, 0, 1, 1, -3, 4));
        zero_q.push_back(tick_of(1, 0, 0, 0, 0, 0));
        zero_q.push_back(tick_of(0, 0, 12, 7, 2, 2));
        zero_q.push_back(tick_of(1, 1, 0, 0, 0, 0));
        zero_q.push_back(tick_of(0, 0, -32768, 1023, -128, -128));
        zero_q.push_back(tick_of(0, 1, 300, 40, 9, 9));
        foreach (zero_q[i])
            push_tick(zero_q[i]);
        settle();

        for (int p = 0; p < RAND_SETS; p++)
        begin
            program_regs(pick_regs(p));
            settings++;
            for (int k = 0; k < RAND_TICKS; k++)
                push_tick(random_tick(board.drive_phase));
            settle();
        end

        // catch any stray result after the last one expected
        repeat (60) @(posedge clk);
        board.summary(settings);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> l_path_drive_controller.f
design/ldc_pkg.sv
design/ldc_smul.sv
design/ldc_sdiv.sv
design/l_path_drive_controller.sv
design/ldc_checker.sv
tb/l_path_drive_controller_tb.sv
